>>> rtl/core/ps2mc_pkg.sv
package ps2mc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COORD_BITS_MIN = 8;
  localparam int unsigned COORD_BITS_MAX = 16;

  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_W     = 12;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 1'd1;

  localparam logic [CFG_W-1:0] X_LIMIT_RST = 12'd1279;
  localparam logic [CFG_W-1:0] Y_LIMIT_RST = 12'd719;

  localparam int unsigned POS_X_RST = 640;
  localparam int unsigned POS_Y_RST = 360;

  localparam logic [BYTE_W-1:0] OVF_Y  = 8'h80;
  localparam logic [BYTE_W-1:0] OVF_X  = 8'h40;
  localparam logic [BYTE_W-1:0] SIGN_Y = 8'h20;
  localparam logic [BYTE_W-1:0] SIGN_X = 8'h10;

  typedef struct packed {
    logic              aux_flag;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] x_limit;
    logic [CFG_W-1:0] y_limit;
  } limits_t;

endpackage

>>> rtl/core/ps2mc_in_if.sv
interface ps2mc_in_if;
  import ps2mc_pkg::*;

  logic              valid;
  logic              ready;
  logic              aux_flag;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output aux_flag, output data_byte, input ready);
  modport sink (input valid, input aux_flag, input data_byte, output ready);

endinterface

>>> rtl/core/ps2mc_out_if.sv
interface ps2mc_out_if;
  import ps2mc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cursor_x;
  logic [OUT_W-1:0] cursor_y;
  logic             dropped;

  modport source (output valid, output cursor_x, output cursor_y, output dropped,
                  input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input dropped,
                output ready);

endinterface

>>> rtl/core/ps2mc_cfg_if.sv
interface ps2mc_cfg_if;
  import ps2mc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);

endinterface

>>> rtl/core/ps2mc_cfg_regs.sv
module ps2mc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [ps2mc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ps2mc_pkg::CFG_W-1:0]     wr_data,
  output ps2mc_pkg::limits_t             limits
);
  import ps2mc_pkg::*;

  limits_t limits_r;
  limits_t limits_nxt;

  assign wr_ready = 1'b1;
  assign limits   = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (wr_valid) begin
      unique case (wr_index)
        REG_X_LIMIT: limits_nxt.x_limit = wr_data;
        REG_Y_LIMIT: limits_nxt.y_limit = wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.x_limit <= X_LIMIT_RST;
      limits_r.y_limit <= Y_LIMIT_RST;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

>>> rtl/core/ps2mc_in_stage.sv
module ps2mc_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ps2mc_pkg::item_t              in_item,
  output logic                          item_valid,
  input  logic                          item_take,
  output ps2mc_pkg::item_t              item
);
  import ps2mc_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/core/ps2mc_core.sv
module ps2mc_core #(
  parameter int unsigned COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_take,
  input  ps2mc_pkg::item_t            item,
  input  ps2mc_pkg::limits_t          limits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ps2mc_pkg::OUT_W-1:0] out_x,
  output logic [ps2mc_pkg::OUT_W-1:0] out_y,
  output logic                        out_dropped
);
  import ps2mc_pkg::*;

  localparam int unsigned SW = COORD_BITS + 2;
  localparam int unsigned CW = COORD_BITS + CFG_W;
  localparam int unsigned WW = COORD_BITS + OUT_W;

  typedef enum logic [1:0] {
    IDX_HEAD = 2'd0,
    IDX_X    = 2'd1,
    IDX_Y    = 2'd2
  } pkt_idx_t;

  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [SW-1:0]  v,
    input logic [COORD_BITS-1:0] lim
  );
    logic [CW-1:0] v_ext;
    logic [CW-1:0] lim_ext;
    v_ext   = {{(CW-SW){1'b0}}, v};
    lim_ext = {{CFG_W{1'b0}}, lim};
    if (v[SW-1]) begin
      clamp_coord = '0;
    end else if (v_ext > lim_ext) begin
      clamp_coord = lim;
    end else begin
      clamp_coord = v[COORD_BITS-1:0];
    end
  endfunction

  pkt_idx_t              idx_r, idx_nxt;
  logic [BYTE_W-1:0]     head_r, head_nxt;
  logic [BYTE_W-1:0]     xbyte_r, xbyte_nxt;
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_x_r, out_x_nxt;
  logic [OUT_W-1:0]      out_y_r, out_y_nxt;
  logic                  dropped_r, dropped_nxt;

  logic                  fire;
  logic                  last;
  logic                  ovf;
  logic signed [SW-1:0]  dx, dy, sum_x, sum_y;
  logic [CW-1:0]         mask_ext, xlim_ext, ylim_ext;
  logic [COORD_BITS-1:0] xlim, ylim;
  logic [WW-1:0]         wide_x, wide_y;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign fire      = item_take && item.aux_flag;
  assign last      = fire && (idx_r != IDX_HEAD) && (idx_r != IDX_X);
  assign ovf       = (head_r & (OVF_X | OVF_Y)) != '0;

  // 9-bit deltas with sign from the head byte
  assign dx = SW'(signed'({(head_r & SIGN_X) != '0, xbyte_r}));
  assign dy = SW'(signed'({(head_r & SIGN_Y) != '0, item.data_byte}));

  assign sum_x = signed'({2'b00, pos_x_r}) + dx;
  assign sum_y = signed'({2'b00, pos_y_r}) - dy;

  // limits saturate to the coordinate range
  assign mask_ext = {{CFG_W{1'b0}}, {COORD_BITS{1'b1}}};
  assign xlim_ext = {{COORD_BITS{1'b0}}, limits.x_limit};
  assign ylim_ext = {{COORD_BITS{1'b0}}, limits.y_limit};
  assign xlim     = (xlim_ext > mask_ext) ? mask_ext[COORD_BITS-1:0] : xlim_ext[COORD_BITS-1:0];
  assign ylim     = (ylim_ext > mask_ext) ? mask_ext[COORD_BITS-1:0] : ylim_ext[COORD_BITS-1:0];

  always_comb begin
    idx_nxt   = idx_r;
    head_nxt  = head_r;
    xbyte_nxt = xbyte_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (fire) begin
      unique case (idx_r)
        IDX_HEAD: begin
          head_nxt = item.data_byte;
          idx_nxt  = IDX_X;
        end
        IDX_X: begin
          xbyte_nxt = item.data_byte;
          idx_nxt   = IDX_Y;
        end
        default: begin
          idx_nxt = IDX_HEAD;
          if (!ovf) begin
            pos_x_nxt = clamp_coord(sum_x, xlim);
            pos_y_nxt = clamp_coord(sum_y, ylim);
          end
        end
      endcase
    end
  end

  assign wide_x        = {{OUT_W{1'b0}}, pos_x_nxt};
  assign wide_y        = {{OUT_W{1'b0}}, pos_y_nxt};
  assign out_x_nxt     = wide_x[OUT_W-1:0];
  assign out_y_nxt     = wide_y[OUT_W-1:0];
  assign dropped_nxt   = ovf;
  assign out_valid_nxt = (out_valid_r && !out_ready) || last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_HEAD;
      head_r      <= '0;
      xbyte_r     <= '0;
      pos_x_r     <= COORD_BITS'(POS_X_RST);
      pos_y_r     <= COORD_BITS'(POS_Y_RST);
      out_valid_r <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      dropped_r   <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      xbyte_r     <= xbyte_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (last) begin
        out_x_r   <= out_x_nxt;
        out_y_r   <= out_y_nxt;
        dropped_r <= dropped_nxt;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_dropped = dropped_r;

endmodule

>>> rtl/core/ps2_mouse_cursor_tracker.sv
// channel   dir  handshake                 payload
// in_bus    in   in_bus.valid/ready        aux_flag, data_byte
// out_bus   out  out_bus.valid/ready       cursor_x, cursor_y, dropped
// cfg_bus   in   cfg_bus.valid/ready       reg_index, wdata (ready always high)
//
// one transaction per cycle on in_bus while the result is not stalled; a byte
// reaches the input register, then the packet state and, with the last byte
// of a packet, the result register
// a stalled result holds in_bus off only once the input register is full
// reset is synchronous active low, no clearing pass
module ps2_mouse_cursor_tracker #(
  parameter int unsigned COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ps2mc_in_if.sink     in_bus,
  ps2mc_out_if.source  out_bus,
  ps2mc_cfg_if.sink    cfg_bus
);
  import ps2mc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  limits_t limits;

  assign in_item.aux_flag  = in_bus.aux_flag;
  assign in_item.data_byte = in_bus.data_byte;

  ps2mc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_bus.valid),
    .wr_ready (cfg_bus.ready),
    .wr_index (cfg_bus.reg_index),
    .wr_data  (cfg_bus.wdata),
    .limits   (limits)
  );

  ps2mc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  ps2mc_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item        (item),
    .limits      (limits),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_x       (out_bus.cursor_x),
    .out_y       (out_bus.cursor_y),
    .out_dropped (out_bus.dropped)
  );

endmodule

>>> rtl/core/ps2mc_checker.sv
module ps2mc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ps2mc_pkg::OUT_W-1:0] out_cursor_x,
  input logic [ps2mc_pkg::OUT_W-1:0] out_cursor_y,
  input logic                        out_dropped,
  input logic                        cfg_ready
);
  import ps2mc_pkg::*;

  logic             seen_r;
  logic [OUT_W-1:0] last_x_r;
  logic [OUT_W-1:0] last_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_x_r <= out_cursor_x;
      last_y_r <= out_cursor_y;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_x) &&
      $stable(out_cursor_y) && $stable(out_dropped))
    else $error("stalled result changed");

  // a dropped packet repeats the last delivered position
  a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped && seen_r |->
      out_cursor_x == last_x_r && out_cursor_y == last_y_r)
    else $error("dropped packet moved the cursor");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind ps2_mouse_cursor_tracker ps2mc_checker u_ps2mc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_cursor_x (out_bus.cursor_x),
  .out_cursor_y (out_bus.cursor_y),
  .out_dropped  (out_bus.dropped),
  .cfg_ready    (cfg_bus.ready)
);
